FILE: design/bnz_pkg.sv
// ----------------------------------------------------------------------------
// bnz_pkg
// shared constants and types of the band neighbor z-score block
// ----------------------------------------------------------------------------
package bnz_pkg;

    localparam int MAX_ROWS    = 64;
    localparam int OFFSET_BITS = 16;
    localparam int RATIO_W     = 16;
    localparam int RAD_W       = 16;
    localparam int ROW_OUT_W   = 6;
    localparam int IDX_W       = $clog2(MAX_ROWS);
    localparam int CNT_W       = $clog2(MAX_ROWS + 1);
    localparam int SUM_W       = RATIO_W + CNT_W;
    localparam int SQ_W        = 2 * RATIO_W + CNT_W;
    localparam int SP_W        = 2 * SUM_W;
    localparam int BN_W        = SUM_W + 8;
    localparam int NN_W        = 2 * BN_W;
    localparam int NUM_W       = NN_W + 2;
    localparam int QW          = 35;
    localparam int DD_W        = CNT_W + 1;
    localparam int ROOT_W      = (QW + 1) / 2;
    localparam int SR_W        = ROOT_W + 1;
    localparam int ITER_W      = $clog2(QW + 1);
    localparam int DELTA_W     = 18;
    localparam int Z_W         = 16;

    localparam logic CFG_INNER = 1'b0;
    localparam logic CFG_OUTER = 1'b1;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] offset;
        logic [RATIO_W-1:0]     ratio;
        logic                   valid;
    } t_row;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             last;
        logic             ovf;
        logic [RATIO_W-1:0] v;
        logic [CNT_W-1:0] n;
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sumsq;
    } t_acc;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SWEEP,
        ST_DRAIN
    } t_ctl_state;

    typedef enum logic [2:0] {
        SC_IDLE,
        SC_MUL,
        SC_DIFF,
        SC_SQR,
        SC_SETUP,
        SC_DIV,
        SC_SQRT,
        SC_OUT
    } t_sc_state;

endpackage

FILE: design/bnz_cell.sv
// ----------------------------------------------------------------------------
// bnz_cell
// one stored row of the ring, loaded in place and rotated to its neighbor
// ----------------------------------------------------------------------------
module bnz_cell import bnz_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  t_row i_load_row,
    input  logic i_shift,
    input  t_row i_next,
    input  logic i_clear,
    output t_row o_row
);

    logic                   r_valid;
    logic [OFFSET_BITS-1:0] r_offset;
    logic [RATIO_W-1:0]     r_ratio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_clear) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_load_row.valid;
        end else if (i_shift) begin
            r_valid <= i_next.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_offset <= i_load_row.offset;
            r_ratio  <= i_load_row.ratio;
        end else if (i_shift) begin
            r_offset <= i_next.offset;
            r_ratio  <= i_next.ratio;
        end
    end

    assign o_row.offset = r_offset;
    assign o_row.ratio  = r_ratio;
    assign o_row.valid  = r_valid;

endmodule

FILE: design/bnz_score.sv
// ----------------------------------------------------------------------------
// bnz_score
// turns one row's neighbor sums into delta and z-score, bit-serial divide
// and square root
// ----------------------------------------------------------------------------
module bnz_score import bnz_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  t_acc                       i_acc,
    output logic                       o_ready,
    output logic                       o_result_valid,
    output logic [ROW_OUT_W-1:0]       o_row_index,
    output logic signed [DELTA_W-1:0]  o_delta_value,
    output logic signed [Z_W-1:0]      o_z_score,
    output logic [ROW_OUT_W-1:0]       o_neighbor_total,
    output logic                       o_final_result,
    output logic                       o_overflow_flag
);

    t_sc_state r_st, n_st;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic r_valid;

    t_acc r_acc;
    logic [SUM_W-1:0]  r_vn;
    logic [SP_W-1:0]   r_nsq;
    logic [SP_W-1:0]   r_sum2;
    logic              r_neg;
    logic [SUM_W-1:0]  r_mag;
    logic [SP_W-1:0]   r_spread;
    logic [NN_W-1:0]   r_nn;
    logic [SUM_W:0]    r_dnum;
    logic [DD_W-1:0]   r_dden;
    logic              r_sat;
    logic              r_zero;
    logic [SP_W:0]     r_rem;
    logic [QW-1:0]     r_qsh;
    logic [QW-1:0]     r_q;
    logic [DD_W:0]     r_drem;
    logic [QW-1:0]     r_dsh;
    logic [QW-1:0]     r_dq;
    logic [QW:0]       r_ssrc;
    logic [SR_W-1:0]   r_srem;
    logic [ROOT_W-1:0] r_root;

    logic [NUM_W-1:0]    w_numer;
    logic [SP_W+QW-1:0]  w_lim;
    logic [BN_W-1:0]     w_bign;
    logic [SP_W:0]       w_t;
    logic [DD_W:0]       w_td;
    logic [SR_W+1:0]     w_r2;
    logic [SR_W+1:0]     w_trial;
    logic [ROOT_W:0]     w_rp1;
    logic [ROOT_W-1:0]   w_zm;
    logic [DELTA_W-1:0]  w_dm;
    logic signed [Z_W-1:0]     w_z;
    logic signed [DELTA_W-1:0] w_delta;

    assign w_bign  = {r_mag, 8'b0};
    assign w_numer = {r_nn, 2'b00};
    assign w_lim   = {r_spread, {QW{1'b0}}};
    assign w_t     = {r_rem[SP_W-1:0], r_qsh[QW-1]};
    assign w_td    = {r_drem[DD_W-1:0], r_dsh[QW-1]};
    assign w_r2    = {r_srem, r_ssrc[QW:QW-1]};
    assign w_trial = (SR_W+2)'({r_root, 2'b01});
    assign w_rp1   = (ROOT_W+1)'(r_root) + 1'b1;
    assign w_zm    = w_rp1[ROOT_W:1];
    assign w_dm    = r_dq[DELTA_W-1:0];

    always_comb begin
        if (r_acc.n == '0) begin
            w_delta = '0;
        end else if (r_neg) begin
            w_delta = -$signed(w_dm);
        end else begin
            w_delta = $signed(w_dm);
        end
        if (r_acc.n == '0 || r_zero) begin
            w_z = '0;
        end else if (r_neg) begin
            if (r_sat || w_zm > ROOT_W'(32768)) begin
                w_z = 16'sh8000;
            end else begin
                w_z = -$signed(Z_W'(w_zm));
            end
        end else begin
            if (r_sat || w_zm > ROOT_W'(32767)) begin
                w_z = 16'sh7fff;
            end else begin
                w_z = $signed(Z_W'(w_zm));
            end
        end
    end

    always_comb begin
        n_st   = r_st;
        n_iter = r_iter;
        case (r_st)
            SC_IDLE:  if (i_start) n_st = SC_MUL;
            SC_MUL:   n_st = SC_DIFF;
            SC_DIFF:  n_st = SC_SQR;
            SC_SQR:   n_st = SC_SETUP;
            SC_SETUP: begin
                n_st   = SC_DIV;
                n_iter = '0;
            end
            SC_DIV: begin
                n_iter = r_iter + 1'b1;
                if (r_iter == ITER_W'(QW - 1)) begin
                    n_st   = SC_SQRT;
                    n_iter = '0;
                end
            end
            SC_SQRT: begin
                n_iter = r_iter + 1'b1;
                if (r_iter == ITER_W'(ROOT_W)) begin
                    n_st = SC_OUT;
                end
            end
            SC_OUT:   n_st = SC_IDLE;
            default:  n_st = SC_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= SC_IDLE;
            r_iter  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_iter  <= n_iter;
            r_valid <= (r_st == SC_OUT);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            SC_IDLE: begin
                if (i_start) r_acc <= i_acc;
            end
            SC_MUL: begin
                r_vn   <= SUM_W'(r_acc.v * r_acc.n);
                r_nsq  <= SP_W'(r_acc.sumsq * r_acc.n);
                r_sum2 <= r_acc.sum * r_acc.sum;
            end
            SC_DIFF: begin
                r_neg    <= (r_vn < r_acc.sum);
                r_mag    <= (r_vn < r_acc.sum) ? r_acc.sum - r_vn : r_vn - r_acc.sum;
                r_spread <= r_nsq - r_sum2;
            end
            SC_SQR: begin
                r_nn   <= w_bign * w_bign;
                r_dnum <= {r_mag, 1'b0} + (SUM_W+1)'(r_acc.n);
                r_dden <= {r_acc.n, 1'b0};
            end
            SC_SETUP: begin
                r_sat  <= ((SP_W+QW)'(w_numer) >= w_lim);
                r_zero <= (r_spread == '0);
                r_rem  <= (SP_W+1)'(w_numer[NUM_W-1:QW]);
                r_qsh  <= w_numer[QW-1:0];
                r_q    <= '0;
                r_drem <= '0;
                r_dsh  <= QW'(r_dnum);
                r_dq   <= '0;
            end
            SC_DIV: begin
                if (w_t >= {1'b0, r_spread}) begin
                    r_rem <= w_t - {1'b0, r_spread};
                    r_q   <= {r_q[QW-2:0], 1'b1};
                end else begin
                    r_rem <= w_t;
                    r_q   <= {r_q[QW-2:0], 1'b0};
                end
                r_qsh <= {r_qsh[QW-2:0], 1'b0};
                if (w_td >= {1'b0, r_dden}) begin
                    r_drem <= w_td - {1'b0, r_dden};
                    r_dq   <= {r_dq[QW-2:0], 1'b1};
                end else begin
                    r_drem <= w_td;
                    r_dq   <= {r_dq[QW-2:0], 1'b0};
                end
                r_dsh <= {r_dsh[QW-2:0], 1'b0};
                if (r_iter == ITER_W'(QW - 1)) begin
                    r_srem <= '0;
                    r_root <= '0;
                end
            end
            SC_SQRT: begin
                if (r_iter == '0) begin
                    r_ssrc <= {1'b0, r_q};
                end
                if (r_iter != '0) begin
                    if (w_r2 >= w_trial) begin
                        r_srem <= SR_W'(w_r2 - w_trial);
                        r_root <= {r_root[ROOT_W-2:0], 1'b1};
                    end else begin
                        r_srem <= SR_W'(w_r2);
                        r_root <= {r_root[ROOT_W-2:0], 1'b0};
                    end
                    r_ssrc <= {r_ssrc[QW-2:0], 2'b00};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_st == SC_OUT) begin
            o_row_index      <= ROW_OUT_W'(r_acc.idx);
            o_delta_value    <= w_delta;
            o_z_score        <= w_z;
            o_neighbor_total <= ROW_OUT_W'(r_acc.n);
            o_final_result   <= r_acc.last;
            o_overflow_flag  <= r_acc.ovf;
        end
    end

    assign o_ready        = (r_st == SC_IDLE);
    assign o_result_valid = r_valid;

endmodule

FILE: design/band_neighbor_zscore_top.sv
// ----------------------------------------------------------------------------
// band_neighbor_zscore_top
// local neighborhood z-score over one group of rows held in a rotating ring
//
//   channel   signals                                        direction
//   ------------------------------------------------------------------
//   command   start, i_position_offset, i_sample_ratio,
//             i_group_end; busy is an output                 in
//   result    o_result_valid, o_row_index, o_delta_value,
//             o_z_score, o_neighbor_total, o_final_result,
//             o_overflow_flag                                out
//   config    i_cfg_we, i_cfg_index, i_cfg_data              in
//
// a row without group end is stored when accepted; rows past MAX_ROWS are dropped
// after group end, each row is rotated once around the whole ring past the
// accumulator, the score unit runs beside the next sweep, which waits for it
// results are one-cycle strobes and cannot be held off
// synchronous active-low reset, config radii reset to 0 and 20
// ----------------------------------------------------------------------------
module band_neighbor_zscore_top import bnz_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [15:0]         i_position_offset,
    input  logic [15:0]                i_sample_ratio,
    input  logic                       i_group_end,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [RAD_W-1:0]           i_cfg_data,
    output logic                       o_result_valid,
    output logic [ROW_OUT_W-1:0]       o_row_index,
    output logic signed [DELTA_W-1:0]  o_delta_value,
    output logic signed [Z_W-1:0]      o_z_score,
    output logic [ROW_OUT_W-1:0]       o_neighbor_total,
    output logic                       o_final_result,
    output logic                       o_overflow_flag
);

    t_ctl_state r_st, n_st;
    logic [RAD_W-1:0] r_inner, r_outer;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_drop, n_drop;
    logic [CNT_W-1:0] r_total, n_total;
    logic [CNT_W-1:0] r_step, n_step;
    logic [IDX_W-1:0] r_row, n_row;
    logic [CNT_W-1:0] r_n;
    logic [SUM_W-1:0] r_sum;
    logic [SQ_W-1:0]  r_sumsq;
    t_row             r_own;

    t_row w_rows [MAX_ROWS];
    t_row w_load_row;
    t_row w_head, w_own;
    logic w_accept, w_store, w_shift, w_clear, w_handoff, w_accum, w_last;
    logic w_sc_ready;
    t_acc w_acc;
    logic signed [OFFSET_BITS:0] w_diff;
    logic [OFFSET_BITS:0]        w_dist;
    logic                        w_inband;

    assign busy       = (r_st != ST_LOAD);
    assign w_accept   = start && !busy;
    assign w_store    = w_accept && (r_cnt < CNT_W'(MAX_ROWS));
    assign w_load_row.offset = i_position_offset[OFFSET_BITS-1:0];
    assign w_load_row.ratio  = i_sample_ratio;
    assign w_load_row.valid  = 1'b1;

    assign w_head = w_rows[0];
    assign w_own  = (r_step == '0) ? w_head : r_own;
    assign w_last = ((CNT_W'(r_row) + 1'b1) == r_total);

    assign w_accum   = (r_st == ST_SWEEP) && (r_step < CNT_W'(MAX_ROWS));
    assign w_handoff = (r_st == ST_SWEEP) && (r_step == CNT_W'(MAX_ROWS)) && w_sc_ready;
    assign w_shift   = w_accum || w_handoff;
    assign w_clear   = (r_st == ST_DRAIN) && w_sc_ready;

    genvar j;
    generate
        for (j = 0; j < MAX_ROWS; j++) begin : g_ring
            bnz_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_load     (w_store && (r_cnt == CNT_W'(j))),
                .i_load_row (w_load_row),
                .i_shift    (w_shift),
                .i_next     (w_rows[(j + 1) % MAX_ROWS]),
                .i_clear    (w_clear),
                .o_row      (w_rows[j])
            );
        end
    endgenerate

    assign w_diff = $signed({w_head.offset[OFFSET_BITS-1], w_head.offset})
                  - $signed({w_own.offset[OFFSET_BITS-1], w_own.offset});
    assign w_dist = w_diff[OFFSET_BITS] ? (OFFSET_BITS+1)'(-w_diff)
                                        : (OFFSET_BITS+1)'(w_diff);
    assign w_inband = w_head.valid && (w_dist != '0)
                   && (w_dist > (OFFSET_BITS+1)'(r_inner))
                   && (w_dist <= (OFFSET_BITS+1)'(r_outer));

    assign w_acc.idx   = r_row;
    assign w_acc.last  = w_last;
    assign w_acc.ovf   = r_drop;
    assign w_acc.v     = r_own.ratio;
    assign w_acc.n     = r_n;
    assign w_acc.sum   = r_sum;
    assign w_acc.sumsq = r_sumsq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner <= '0;
            r_outer <= RAD_W'(20);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_INNER: r_inner <= i_cfg_data;
                CFG_OUTER: r_outer <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_st    = r_st;
        n_cnt   = r_cnt;
        n_drop  = r_drop;
        n_total = r_total;
        n_step  = r_step;
        n_row   = r_row;
        case (r_st)
            ST_LOAD: begin
                if (w_accept) begin
                    if (w_store) begin
                        n_cnt = r_cnt + 1'b1;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_group_end) begin
                        n_total = w_store ? r_cnt + 1'b1 : r_cnt;
                        n_st    = ST_SWEEP;
                        n_step  = '0;
                        n_row   = '0;
                    end
                end
            end
            ST_SWEEP: begin
                if (w_accum) begin
                    n_step = r_step + 1'b1;
                end else if (w_handoff) begin
                    n_step = '0;
                    if (w_last) begin
                        n_st = ST_DRAIN;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                if (w_sc_ready) begin
                    n_st   = ST_LOAD;
                    n_cnt  = '0;
                    n_drop = 1'b0;
                end
            end
            default: n_st = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_LOAD;
            r_cnt   <= '0;
            r_drop  <= 1'b0;
            r_total <= '0;
            r_step  <= '0;
            r_row   <= '0;
            r_n     <= '0;
            r_sum   <= '0;
            r_sumsq <= '0;
        end else begin
            r_st    <= n_st;
            r_cnt   <= n_cnt;
            r_drop  <= n_drop;
            r_total <= n_total;
            r_step  <= n_step;
            r_row   <= n_row;
            if (w_handoff) begin
                r_n     <= '0;
                r_sum   <= '0;
                r_sumsq <= '0;
            end else if (w_accum && w_inband) begin
                r_n     <= r_n + 1'b1;
                r_sum   <= r_sum + SUM_W'(w_head.ratio);
                r_sumsq <= r_sumsq + SQ_W'(w_head.ratio * w_head.ratio);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accum && r_step == '0) begin
            r_own <= w_head;
        end
    end

    bnz_score u_score (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (w_handoff),
        .i_acc            (w_acc),
        .o_ready          (w_sc_ready),
        .o_result_valid   (o_result_valid),
        .o_row_index      (o_row_index),
        .o_delta_value    (o_delta_value),
        .o_z_score        (o_z_score),
        .o_neighbor_total (o_neighbor_total),
        .o_final_result   (o_final_result),
        .o_overflow_flag  (o_overflow_flag)
    );

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the band neighbor z-score block against a predictor of its own.
// Rows are sent in groups with random gaps. Each group-end row yields the
// expected results, which are compared field by field with the strobed
// outputs. The radii are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
    import bnz_pkg::*;

    typedef struct {
        logic [5:0]  row;
        logic [17:0] delta;
        logic [15:0] z;
        logic [5:0]  n;
        logic        fin;
        logic        ovf;
    } t_score;

    class zscore_board;
        logic [15:0] offs[MAX_ROWS];
        logic [15:0] rats[MAX_ROWS];
        int unsigned loaded;
        bit          dropped;
        logic [15:0] inner;
        logic [15:0] outer;
        t_score      pending[$];
        int          errors;

        function new();
            loaded  = 0;
            dropped = 0;
            inner   = 16'd0;
            outer   = 16'd20;
            errors  = 0;
        endfunction

        function void set_radius(logic idx, logic [15:0] val);
            if (idx == CFG_INNER) inner = val;
            else outer = val;
        endfunction

        function longint unsigned int_sqrt(longint unsigned x);
            longint unsigned res;
            longint unsigned bit_w;
            res   = 0;
            bit_w = 64'd1 << 62;
            while (bit_w > x) bit_w = bit_w >> 2;
            while (bit_w != 0) begin
                if (x >= res + bit_w) begin
                    x   = x - (res + bit_w);
                    res = (res >> 1) + bit_w;
                end else begin
                    res = res >> 1;
                end
                bit_w = bit_w >> 2;
            end
            return res;
        endfunction

        function t_score score(int unsigned idx);
            t_score r;
            longint own, diff, num, dl, zs;
            longint unsigned d, w, v, n, sum, sumsq, mag, dm, spread, bn, s, zm;
            own = longint'($signed(offs[idx]));
            v = rats[idx];
            n = 0; sum = 0; sumsq = 0; dl = 0; zs = 0;
            for (int k = 0; k < loaded; k++) begin
                diff = longint'($signed(offs[k])) - own;
                d = diff < 0 ? longint'(-diff) : diff;
                w = rats[k];
                if (d == 0 || d <= inner || d > outer) continue;
                n++;
                sum += w;
                sumsq += w * w;
            end
            if (n != 0) begin
                num = longint'(v * n) - longint'(sum);
                mag = num < 0 ? -num : num;
                dm = (2 * mag + n) / (2 * n);
                dl = num < 0 ? -longint'(dm) : longint'(dm);
                if (n * sumsq > sum * sum) begin
                    spread = n * sumsq - sum * sum;
                    bn = mag << 8;
                    s = int_sqrt((4 * bn * bn) / spread);
                    zm = (s + 1) >> 1;
                    if (num < 0) zs = zm > 32768 ? -32768 : -longint'(zm);
                    else zs = zm > 32767 ? 32767 : longint'(zm);
                end
            end
            r.row = idx[5:0];
            r.delta = dl[17:0];
            r.z = zs[15:0];
            r.n = n[5:0];
            r.fin = 0;
            r.ovf = 0;
            return r;
        endfunction

        function void note_row(logic [15:0] off, logic [15:0] rat, logic ge);
            t_score r;
            if (loaded < MAX_ROWS) begin
                offs[loaded] = off;
                rats[loaded] = rat;
                loaded++;
            end else begin
                dropped = 1;
            end
            if (ge) begin
                for (int i = 0; i < loaded; i++) begin
                    r = score(i);
                    r.fin = (i + 1 == loaded);
                    r.ovf = dropped;
                    pending = {pending, r};
                end
                loaded = 0;
                dropped = 0;
            end
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0h want %0h", what, got, want);
            errors++;
        endtask

        task check_result(logic [5:0] row, logic [17:0] delta, logic [15:0] z,
                          logic [5:0] n, logic fin, logic ovf);
            t_score e;
            if (pending.size() == 0) begin
                report("unexpected result row", row, 0);
                return;
            end
            e = pending.pop_front();
            if (row !== e.row) report("row_index", row, e.row);
            if (delta !== e.delta) report("delta_value", delta, e.delta);
            if (z !== e.z) report("z_score", z, e.z);
            if (n !== e.n) report("neighbor_total", n, e.n);
            if (fin !== e.fin) report("final_result", fin, e.fin);
            if (ovf !== e.ovf) report("overflow_flag", ovf, e.ovf);
        endtask
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic start = 0;
    logic busy;
    logic signed [15:0] i_position_offset = 0;
    logic [15:0] i_sample_ratio = 0;
    logic i_group_end = 0;
    logic i_cfg_we = 0;
    logic i_cfg_index = 0;
    logic [RAD_W-1:0] i_cfg_data = 0;
    logic o_result_valid;
    logic [ROW_OUT_W-1:0] o_row_index;
    logic signed [DELTA_W-1:0] o_delta_value;
    logic signed [Z_W-1:0] o_z_score;
    logic [ROW_OUT_W-1:0] o_neighbor_total;
    logic o_final_result;
    logic o_overflow_flag;

    zscore_board board = new();
    int idle_cycles = 0;

    band_neighbor_zscore_top dut (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid)
            board.check_result(o_row_index, o_delta_value, o_z_score,
                               o_neighbor_total, o_final_result, o_overflow_flag);
        if (i_rst_n && (o_result_valid || (start && !busy))) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("FAIL");
            $finish;
        end
    end

    task send_row(logic [15:0] off, logic [15:0] rat, logic ge);
        int gap;
        bit taken;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(negedge i_clk);
        end
        i_position_offset <= off;
        i_sample_ratio <= rat;
        i_group_end <= ge;
        start <= 1;
        taken = 0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !busy;
        end
        board.note_row(off, rat, ge);
        @(negedge i_clk);
    endtask

    // wait for the block to drain, then write one radius
    task write_radius(logic idx, logic [15:0] val);
        start <= 0;
        @(negedge i_clk);
        wait (board.pending.size() == 0);
        repeat (150) @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        board.set_radius(idx, val);
    endtask

    task random_group(int rows);
        logic [15:0] off, rat;
        for (int i = 0; i < rows; i++) begin
            if ($urandom_range(0, 4) == 0) off = $urandom();
            else off = 16'($signed($urandom_range(0, 60)) - 30);
            case ($urandom_range(0, 5))
                0: rat = 16'h0000;
                1: rat = 16'hffff;
                2: rat = 16'h8000 + 16'($urandom_range(0, 3));
                default: rat = $urandom();
            endcase
            send_row(off, rat, i == rows - 1);
        end
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        // single row, no neighbors
        send_row(16'd7, 16'hffff, 1);
        // equal values, zero spread
        send_row(16'd0, 16'h8000, 0);
        send_row(16'd5, 16'h8000, 0);
        send_row(16'd10, 16'h8000, 1);
        // extreme offsets and values, duplicate offset
        send_row(16'h8000, 16'h0000, 0);
        send_row(16'h7fff, 16'hffff, 0);
        send_row(16'h0000, 16'h0001, 0);
        send_row(16'h0000, 16'hffff, 0);
        send_row(16'hfff0, 16'h1234, 1);
        write_radius(CFG_OUTER, 16'hffff);
        send_row(16'h8000, 16'h0000, 0);
        send_row(16'h7fff, 16'hffff, 0);
        send_row(16'h0001, 16'h0000, 0);
        send_row(16'h0002, 16'h0000, 1);
        // capacity exceeded, group end on a dropped row
        random_group(MAX_ROWS + 2);
        write_radius(CFG_INNER, 16'hffff);
        random_group(4);
        write_radius(CFG_INNER, 16'd5);
        write_radius(CFG_OUTER, 16'd10);
        for (int g = 0; g < 2; g++) random_group($urandom_range(1, 8));
        write_radius(CFG_OUTER, 16'd0);
        random_group(3);
        write_radius(CFG_INNER, 16'd0);
        write_radius(CFG_OUTER, 16'd20);
        for (int g = 0; g < 2; g++) random_group($urandom_range(1, 8));
        write_radius(CFG_INNER, 16'd2);
        write_radius(CFG_OUTER, 16'd40);
        for (int g = 0; g < 2; g++) random_group($urandom_range(2, 8));
        start <= 0;
        wait (board.pending.size() == 0);
        repeat (200) @(negedge i_clk);
        if (board.errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule

FILE: sim.f
design/bnz_pkg.sv
design/bnz_cell.sv
design/bnz_score.sv
design/band_neighbor_zscore_top.sv
sim/testbench.sv
